@@ rtl/core/refbuf_pkg.sv @@
// ----------------------------------------------------------------------------
// refbuf_pkg
// Shared sizes, status codes and types of the reference-counted allocator.
// ----------------------------------------------------------------------------
package refbuf_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int DEPTH_W  = $clog2(CAPACITY + 1);

   localparam int FIELD_W  = 8;
   localparam int USED_W   = 9;

   typedef enum logic {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_RELEASE = 2'd1,
      ST_EXHAUSTED   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [FIELD_W-1:0] data;
   } mem_wr_type;

endpackage

@@ rtl/core/refbuf_if.sv @@
// ----------------------------------------------------------------------------
// refbuf_req_if / refbuf_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface refbuf_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] consumer_count;
   logic [7:0] release_index;

   modport source (output valid, output func, output consumer_count,
                   output release_index, input ready);
   modport sink   (input valid, input func, input consumer_count,
                   input release_index, output ready);
endinterface

interface refbuf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] granted_index;
   logic [1:0] status;
   logic [8:0] buffers_used;

   modport source (output valid, output granted_index, output status,
                   output buffers_used, input ready);
   modport sink   (input valid, input granted_index, input status,
                   input buffers_used, output ready);
endinterface

@@ rtl/core/refbuf_store.sv @@
// ----------------------------------------------------------------------------
// refbuf_store
// Count memory and free-stack memory, one write and one registered read each.
// ----------------------------------------------------------------------------
module refbuf_store (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [refbuf_pkg::IDX_W-1:0]     cnt_rd_addr,
   input  logic [refbuf_pkg::IDX_W-1:0]     stk_rd_addr,
   input  refbuf_pkg::mem_wr_type           cnt_wr,
   input  refbuf_pkg::mem_wr_type           stk_wr,
   output logic [refbuf_pkg::FIELD_W-1:0]   cnt_rd_data,
   output logic [refbuf_pkg::FIELD_W-1:0]   stk_rd_data
);
   import refbuf_pkg::*;

   logic [FIELD_W-1:0] cnt_mem [CAPACITY];
   logic [FIELD_W-1:0] stk_mem [CAPACITY];
   logic [FIELD_W-1:0] cnt_rd_ff;
   logic [FIELD_W-1:0] stk_rd_ff;

   always_ff @(posedge clock) begin
      if (cnt_wr.en) begin
         cnt_mem[cnt_wr.addr] <= cnt_wr.data;
      end
      if (rd_en) begin
         cnt_rd_ff <= cnt_mem[cnt_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_wr.en) begin
         stk_mem[stk_wr.addr] <= stk_wr.data;
      end
      if (rd_en) begin
         stk_rd_ff <= stk_mem[stk_rd_addr];
      end
   end

   assign cnt_rd_data = cnt_rd_ff;
   assign stk_rd_data = stk_rd_ff;

endmodule

@@ rtl/core/refcounted_buffer_allocator.sv @@
// ----------------------------------------------------------------------------
// refcounted_buffer_allocator
// Buffer allocator with per-buffer reference counts and a LIFO free stack.
// ----------------------------------------------------------------------------
//  channel    dir  handshake             payload
//  req_chan   in   valid/ready           func, consumer_count, release_index
//  rsp_chan   out  valid/ready           granted_index, status, buffers_used
//
//  Each request first reads the count and free-stack memories, then
//  modifies, writes back and loads the result register.
//  A new request is taken while a result waits; the modify cycle holds
//  while the result register is still full.
//  Reset clears the stack depth and fresh-index counter; counts at or above
//  the fresh index read as zero, so the memories need no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_buffer_allocator (
   input  logic         clock,
   input  logic         reset,
   refbuf_req_if.sink   req_chan,
   refbuf_rsp_if.source rsp_chan
);
   import refbuf_pkg::*;

   state_type             state_ff, state_in;
   logic                  func_ff;
   logic [FIELD_W-1:0]    count_ff;
   logic [FIELD_W-1:0]    rel_ff;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic [DEPTH_W-1:0]    fresh_ff, fresh_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]    rsp_index_ff, rsp_index_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  req_xfer;
   logic                  exec_go;
   logic [IDX_W-1:0]      stk_top_addr;
   logic [FIELD_W-1:0]    cnt_rd_data;
   logic [FIELD_W-1:0]    stk_rd_data;
   logic [FIELD_W-1:0]    cnt_cur;
   logic [FIELD_W-1:0]    cnt_dec;
   logic                  rel_filled;
   mem_wr_type            cnt_wr;
   mem_wr_type            stk_wr;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign exec_go        = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign stk_top_addr   = IDX_W'(depth_ff - DEPTH_W'(1));

   refbuf_store u_store (
      .clock       (clock),
      .rd_en       (req_xfer),
      .cnt_rd_addr (IDX_W'(req_chan.release_index)),
      .stk_rd_addr (stk_top_addr),
      .cnt_wr      (cnt_wr),
      .stk_wr      (stk_wr),
      .cnt_rd_data (cnt_rd_data),
      .stk_rd_data (stk_rd_data)
   );

   assign rel_filled = int'(rel_ff) < int'(fresh_ff);
   assign cnt_cur    = rel_filled ? cnt_rd_data : '0;
   assign cnt_dec    = cnt_cur - FIELD_W'(1);

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      cnt_wr        = '0;
      stk_wr        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_index_in  = '0;
               rsp_status_in = ST_OK;
               if (func_ff == FUNC_ALLOC) begin
                  // pop the free stack first, then take a fresh index
                  if (depth_ff != '0) begin
                     depth_in     = depth_ff - DEPTH_W'(1);
                     cnt_wr.en    = 1'b1;
                     cnt_wr.addr  = IDX_W'(stk_rd_data);
                     cnt_wr.data  = count_ff;
                     rsp_index_in = stk_rd_data;
                  end else if (int'(fresh_ff) < CAPACITY) begin
                     fresh_in     = fresh_ff + DEPTH_W'(1);
                     cnt_wr.en    = 1'b1;
                     cnt_wr.addr  = IDX_W'(fresh_ff);
                     cnt_wr.data  = count_ff;
                     rsp_index_in = FIELD_W'(fresh_ff);
                  end else begin
                     rsp_status_in = ST_EXHAUSTED;
                  end
               end else begin
                  if (!rel_filled || cnt_cur == '0) begin
                     rsp_status_in = ST_BAD_RELEASE;
                  end else begin
                     cnt_wr.en   = 1'b1;
                     cnt_wr.addr = IDX_W'(rel_ff);
                     cnt_wr.data = cnt_dec;
                     // push on last release
                     if (cnt_dec == '0 && int'(depth_ff) < CAPACITY) begin
                        stk_wr.en   = 1'b1;
                        stk_wr.addr = IDX_W'(depth_ff);
                        stk_wr.data = rel_ff;
                        depth_in    = depth_ff + DEPTH_W'(1);
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff  <= req_chan.func;
         count_ff <= req_chan.consumer_count;
         rel_ff   <= req_chan.release_index;
      end
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.granted_index = rsp_index_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.buffers_used  = USED_W'(fresh_ff);

endmodule

@@ rtl/core/refbuf_checker.sv @@
// ----------------------------------------------------------------------------
// refbuf_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module refbuf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_granted_index,
   input logic [1:0] rsp_status,
   input logic [8:0] rsp_buffers_used
);
   import refbuf_pkg::*;

   logic [8:0] last_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_used_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_used_ff <= rsp_buffers_used;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a request two cycles earlier");

   a_fail_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EXHAUSTED || rsp_status == ST_BAD_RELEASE)
      |-> rsp_granted_index == '0)
      else $error("failed request carries an index");

   a_used_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_buffers_used >= last_used_ff
                     && int'(rsp_buffers_used) <= CAPACITY))
      else $error("high-water count went back or past capacity");

endmodule

bind refcounted_buffer_allocator refbuf_checker u_refbuf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_granted_index (rsp_chan.granted_index),
   .rsp_status        (rsp_chan.status),
   .rsp_buffers_used  (rsp_chan.buffers_used)
);
